### rtl/core/srr_pkg.sv
// Package for the server registry replay block: action and status codes,
// table entry layout and match flags. No dependencies.
package srr_pkg;

	typedef enum logic [2:0] {
		ACT_ADD       = 3'd0,
		ACT_DELETE    = 3'd1,
		ACT_NEW_ADDR  = 3'd2,
		ACT_NEW_ID    = 3'd3,
		ACT_MAINT_ON  = 3'd4,
		ACT_MAINT_OFF = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_MISMATCH = 2'd1,
		STS_FULL     = 2'd2
	} status_t;

	localparam int STAMP_W = 32;

	typedef struct packed {
		logic [31:0]        ip;
		logic [15:0]        port;
		logic [15:0]        id;
		logic               maint;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic key_hit;
		logic id_hit;
		logic newer;
	} hit_t;

endpackage

### rtl/core/srr_if.sv
// Handshake channels of the server registry replay block.
// Depends on nothing; payload widths are fixed by the word layout.
interface srr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] ip_address;
	logic [15:0] port_number;
	logic [15:0] server_id;
	modport source (output valid, action, ip_address, port_number, server_id, input ready);
	modport sink (input valid, action, ip_address, port_number, server_id, output ready);
endinterface

interface srr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [8:0]  server_count;
	logic [8:0]  disconnected_count;
	logic [8:0]  maint_disconnected_count;
	logic        have_all;
	logic        have_majority;
	logic        replicate_ok;
	logic [31:0] version_count;
	modport source (output valid, status, server_count, disconnected_count,
		maint_disconnected_count, have_all, have_majority, replicate_ok, version_count,
		input ready);
	modport sink (input valid, status, server_count, disconnected_count,
		maint_disconnected_count, have_all, have_majority, replicate_ok, version_count,
		output ready);
endinterface

### rtl/core/srr_match.sv
// Shared compare unit: checks one table entry against the word under work.
// Depends on srr_pkg.
module srr_match import srr_pkg::*; (
	input  logic        valid,
	input  entry_t      ent,
	input  logic [31:0] ip,
	input  logic [15:0] port,
	input  logic [15:0] id,
	input  logic        have_key,
	input  logic [STAMP_W-1:0] best_stamp,
	output hit_t        hit
);
	always_comb begin
		hit.key_hit = valid && (ent.ip == ip) && (ent.port == port);
		hit.id_hit  = valid && (id != 16'd0) && (ent.id == id);
		hit.newer   = !have_key || (ent.stamp > best_stamp);
	end
endmodule

### rtl/core/server_registry_replay_unit.sv
// Top level of the server registry replay block.
// Depends on srr_pkg, srr_req_if / srr_rsp_if and srr_match.
//
// Usage:
//   req carries one operation word (action, ip_address, port_number,
//   server_id); rsp returns one word per operation with the status, the
//   server counts, the three quorum flags and the version count.
//   An operation sweeps the whole slot table through a single read port of
//   the entry memory, one slot a cycle, through one shared compare unit;
//   the result is registered by the apply step, and req is ready again
//   only once that step is done, so a new word is not taken while one is
//   in work. The sweep finds the newest entry with the key, the entry
//   holding the id, and the first free slot; the apply step then makes the
//   change with at most one memory write.
//   Reset clears the valid bits, counters, version and recency stamp at
//   once; entry contents need no clearing, so no sweep follows reset.
//   A result waits in the output register while rsp is stalled; the next
//   word is still accepted and swept, and only its apply step holds until
//   the output register is free.
module server_registry_replay_unit import srr_pkg::*; #(
	parameter int NUM_SLOTS = 256,
	parameter int ID_SPACE  = 65536
) (
	input  logic clk,
	input  logic arst_n,
	srr_req_if.sink   req,
	srr_rsp_if.source rsp
);
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1) + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_APPLY = 4'b1000
	} state_t;

	state_t state_q;
	logic [2:0]  act_q;
	logic [31:0] ip_q;
	logic [15:0] port_q;
	logic [15:0] id_q;

	entry_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	entry_t rd_s1;
	logic rd_v_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic [SLOT_W-1:0] idx_q;

	logic key_found_q, id_found_q, free_found_q;
	logic [SLOT_W-1:0] key_slot_q, id_slot_q, free_slot_q;
	entry_t key_ent_q, id_ent_q;

	logic [CNT_W-1:0] total_q, maint_q;
	logic [31:0] ver_q;
	logic [STAMP_W-1:0] stamp_q;

	logic out_v_q;
	logic [1:0] sts_q;

	hit_t hit;
	logic accept, last_idx, out_free, do_apply;
	status_t sts;
	logic wr_en, set_v, clr_v, id_in_space;
	logic [SLOT_W-1:0] wr_slot;
	entry_t wr_ent;
	logic [CNT_W-1:0] total_d, maint_d;
	logic [CNT_W:0] half;

	srr_match u_match (
		.valid(rd_v_s1 && valid_q[rd_idx_s1]), .ent(rd_s1),
		.ip(ip_q), .port(port_q), .id(id_q),
		.have_key(key_found_q), .best_stamp(key_ent_q.stamp), .hit(hit)
	);

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign last_idx = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign out_free = !out_v_q || rsp.ready;
	assign do_apply = (state_q == ST_APPLY) && out_free;
	assign id_in_space = (id_q != 16'd0) && (32'(id_q) < ID_SPACE);

	always_comb begin
		sts     = STS_MISMATCH;
		wr_en   = 1'b0;
		set_v   = 1'b0;
		clr_v   = 1'b0;
		wr_slot = key_slot_q;
		wr_ent  = key_ent_q;
		total_d = total_q;
		maint_d = maint_q;
		case (act_q)
			ACT_ADD: begin
				if (!key_found_q && (id_q == 16'd0 || (id_in_space && !id_found_q))) begin
					if (!free_found_q) begin
						sts = STS_FULL;
					end else begin
						sts     = STS_OK;
						wr_en   = 1'b1;
						set_v   = 1'b1;
						wr_slot = free_slot_q;
						wr_ent  = '{ip: ip_q, port: port_q, id: id_q, maint: 1'b0,
							stamp: stamp_q};
						total_d = total_q + 1'b1;
					end
				end
			end
			ACT_DELETE: begin
				if (key_found_q) begin
					sts     = STS_OK;
					clr_v   = 1'b1;
					total_d = total_q - 1'b1;
					if (key_ent_q.maint) maint_d = maint_q - 1'b1;
				end
			end
			ACT_NEW_ADDR: begin
				if (id_in_space && id_found_q) begin
					sts          = STS_OK;
					wr_en        = 1'b1;
					wr_slot      = id_slot_q;
					wr_ent       = id_ent_q;
					wr_ent.ip    = ip_q;
					wr_ent.port  = port_q;
					wr_ent.stamp = stamp_q;
				end
			end
			ACT_NEW_ID: begin
				if (id_in_space && !id_found_q && key_found_q) begin
					sts       = STS_OK;
					wr_en     = 1'b1;
					wr_ent.id = id_q;
				end
			end
			ACT_MAINT_ON: begin
				if (key_found_q && !key_ent_q.maint) begin
					sts          = STS_OK;
					wr_en        = 1'b1;
					wr_ent.maint = 1'b1;
					maint_d      = maint_q + 1'b1;
				end
			end
			ACT_MAINT_OFF: begin
				if (key_found_q && key_ent_q.maint) begin
					sts          = STS_OK;
					wr_en        = 1'b1;
					wr_ent.maint = 1'b0;
					maint_d      = maint_q - 1'b1;
				end
			end
			default: sts = STS_MISMATCH;
		endcase
	end

	// entry memory: one read per sweep cycle, at most one write at apply
	always_ff @(posedge clk) begin
		rd_s1 <= mem[idx_q];
		if (do_apply && wr_en) mem[wr_slot] <= wr_ent;
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			act_q  <= req.action;
			ip_q   <= req.ip_address;
			port_q <= req.port_number;
			id_q   <= req.server_id;
		end
		if (rd_v_s1) begin
			if (hit.key_hit && hit.newer) begin
				key_slot_q <= rd_idx_s1;
				key_ent_q  <= rd_s1;
			end
			if (hit.id_hit) begin
				id_slot_q <= rd_idx_s1;
				id_ent_q  <= rd_s1;
			end
			if (!free_found_q && !valid_q[rd_idx_s1]) free_slot_q <= rd_idx_s1;
		end
		if (do_apply) sts_q <= sts;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			rd_v_s1      <= 1'b0;
			valid_q      <= '0;
			key_found_q  <= 1'b0;
			id_found_q   <= 1'b0;
			free_found_q <= 1'b0;
			total_q      <= '0;
			maint_q      <= '0;
			ver_q        <= '0;
			stamp_q      <= '0;
			out_v_q      <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (rd_v_s1) begin
				if (hit.key_hit) key_found_q <= 1'b1;
				if (hit.id_hit) id_found_q <= 1'b1;
				if (!valid_q[rd_idx_s1]) free_found_q <= 1'b1;
			end
			if (do_apply) out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						key_found_q  <= 1'b0;
						id_found_q   <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last_idx) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_APPLY;
				ST_APPLY: begin
					if (out_free) begin
						if (set_v) valid_q[wr_slot] <= 1'b1;
						if (clr_v) valid_q[key_slot_q] <= 1'b0;
						if (wr_en && (act_q == ACT_ADD || act_q == ACT_NEW_ADDR)) begin
							stamp_q <= stamp_q + 1'b1;
						end
						if (sts == STS_OK) ver_q <= ver_q + 1'b1;
						total_q <= total_d;
						maint_q <= maint_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// every replayed server is disconnected, so the down count is the total
	assign half = ({1'b0, total_q} + 1'b1) >> 1;
	assign rsp.valid                    = out_v_q;
	assign rsp.status                   = sts_q;
	assign rsp.server_count             = 9'(total_q);
	assign rsp.disconnected_count       = 9'(total_q);
	assign rsp.maint_disconnected_count = 9'(maint_q);
	assign rsp.have_all                 = (total_q == '0);
	assign rsp.have_majority            = (total_q == '0) || ({1'b0, total_q} < half);
	assign rsp.replicate_ok             = !((total_q != '0) && (total_q == maint_q));
	assign rsp.version_count            = ver_q;

`ifndef SYNTHESIS
	a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && (idx_q == '0))
		else $error("accepted word did not start a sweep");
	a_maint_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		maint_q <= total_q)
		else $error("maintenance count above server count");
	a_version_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		do_apply && (sts == STS_OK) |=> ver_q == $past(ver_q) + 32'd1)
		else $error("version did not advance on a successful word");
	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		do_apply |=> out_v_q && (state_q == ST_IDLE))
		else $error("apply step left no result");
`endif

endmodule
